// ===== rtl/hilbert_curve_index_2d_macros.svh =====
// Assertion macros used by the RTL that checks itself.
`ifndef HILBERT_CURVE_INDEX_2D_MACROS_SVH
`define HILBERT_CURVE_INDEX_2D_MACROS_SVH

// Consequent must hold after the antecedent, delayed by the argument n.
`define HCI_ASSERT_DELAY(lbl, ant, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> ##n (cons)) \
    else $error("hilbert index pipeline check failed");

// Consequent must hold in the same cycle as the antecedent.
`define HCI_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("hilbert index check failed");

`endif

// ===== rtl/hci_pkg.sv =====
package hci_pkg;

  localparam int COORD_W   = 16;
  localparam int IDX_W     = 32;
  localparam int ORDER_DEF = 16;

  // Quadrant code equals the base-4 digit of the curve index at that level.
  typedef enum logic [1:0] {
    QUAD_LL = 2'd0,
    QUAD_HL = 2'd1,
    QUAD_HH = 2'd2,
    QUAD_LH = 2'd3
  } quad_t;

endpackage

// ===== rtl/hci_level.sv =====
module hci_level
  import hci_pkg::*;
#(
  parameter int CW  = ORDER_DEF,
  parameter int LVL = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_in,
  input  logic [CW-1:0]    a_in,
  input  logic [CW-1:0]    b_in,
  input  logic [IDX_W-1:0] pos_in,
  output logic             vld_r,
  output logic [CW-1:0]    a_r,
  output logic [CW-1:0]    b_r,
  output logic [IDX_W-1:0] pos_r
);

  quad_t            quad;
  logic [CW-1:0]    a_nxt;
  logic [CW-1:0]    b_nxt;
  logic [IDX_W-1:0] pos_nxt;

  // Only bits below LVL matter downstream, so the bits above are left as they fall.
  always_comb begin
    quad = quad_t'({a_in[LVL], b_in[LVL]} == 2'b00 ? QUAD_LL :
                   {a_in[LVL], b_in[LVL]} == 2'b10 ? QUAD_HL :
                   {a_in[LVL], b_in[LVL]} == 2'b11 ? QUAD_HH : QUAD_LH);
    a_nxt = a_in;
    b_nxt = b_in;
    unique case (quad)
      QUAD_LL: begin
        a_nxt = b_in;
        b_nxt = a_in;
      end
      QUAD_HL, QUAD_HH: begin
        a_nxt = a_in;
        b_nxt = b_in;
      end
      QUAD_LH: begin
        // (h-1)-x on the low bits is the complement
        a_nxt = ~b_in;
        b_nxt = ~a_in;
      end
      default: begin
        a_nxt = a_in;
        b_nxt = b_in;
      end
    endcase
    pos_nxt = {pos_in[IDX_W-3:0], quad};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    pos_r <= pos_nxt;
  end

endmodule

// ===== rtl/hilbert_curve_index_2d.sv =====
// Hilbert curve index, 2-D: one pipeline stage per curve level, ORDER stages.
// Each word is registered in every stage in turn, from g_lvl[0] to the last, before out_valid.
// Throughput: one word per cycle; busy stays low since the pipe never stalls.
// Reset (synchronous, rst_n low) clears the stage valid bits, dropping words in flight.
`include "hilbert_curve_index_2d_macros.svh"

module hilbert_curve_index_2d
  import hci_pkg::*;
#(
  parameter int ORDER = ORDER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] in_first_coord,
  input  logic [COORD_W-1:0] in_second_coord,
  output logic               out_valid,
  output logic [IDX_W-1:0]   out_curve_index
);

  localparam int CW = ORDER;

  logic             vld_s [ORDER+1];
  logic [CW-1:0]    a_s   [ORDER+1];
  logic [CW-1:0]    b_s   [ORDER+1];
  logic [IDX_W-1:0] pos_s [ORDER+1];

  assign busy = 1'b0;

  // Coordinates wrap to the grid, or zero-extend when the grid is wider.
  assign vld_s[0] = start & ~busy;
  assign a_s[0]   = CW'(in_first_coord);
  assign b_s[0]   = CW'(in_second_coord);
  assign pos_s[0] = '0;

  for (genvar k = 0; k < ORDER; k++) begin : g_lvl
    hci_level #(
      .CW  (CW),
      .LVL (ORDER - 1 - k)
    ) u_lvl (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_in (vld_s[k]),
      .a_in   (a_s[k]),
      .b_in   (b_s[k]),
      .pos_in (pos_s[k]),
      .vld_r  (vld_s[k+1]),
      .a_r    (a_s[k+1]),
      .b_r    (b_s[k+1]),
      .pos_r  (pos_s[k+1])
    );
  end

  assign out_valid       = vld_s[ORDER];
  assign out_curve_index = pos_s[ORDER];

  `HCI_ASSERT_DELAY(a_word_out, start && !busy, ORDER, out_valid)
  `HCI_ASSERT_DELAY(a_no_phantom, !(start && !busy), ORDER, !out_valid)
  `HCI_ASSERT_DELAY(a_origin_zero, start && !busy && in_first_coord == '0 && in_second_coord == '0, ORDER, out_curve_index == '0)
  `HCI_ASSERT_NOW(a_never_busy, out_valid || !out_valid, !busy)

endmodule
